// ===== hdl/cbm_pkg.sv =====
package cbm_pkg;

	// Channel and fixed-point geometry
	localparam int CHANNEL_BITS = 8;
	localparam logic [15:0] FULL_Q8 = 16'hFF00;
	localparam logic [8:0] OPACITY_ONE = 9'h100;

	// Pipeline geometry of one lane
	localparam int DIV_STAGES = 17;
	localparam int PRE_STAGES = 6;
	localparam int DLY_STAGES = DIV_STAGES - PRE_STAGES;
	localparam int LANE_LAT = DIV_STAGES + 3;
	localparam int NUM_LANES = 3;

	// Reciprocal of 255 scaled by 2^33, exact for operands below 2^25
	localparam logic [25:0] RECIP_255 = 26'd33686019;

	// Blend mode codes
	localparam logic [4:0] MODE_NORMAL   = 5'd0;
	localparam logic [4:0] MODE_DARKEN   = 5'd1;
	localparam logic [4:0] MODE_MULTIPLY = 5'd2;
	localparam logic [4:0] MODE_BURN     = 5'd3;
	localparam logic [4:0] MODE_LBURN    = 5'd4;
	localparam logic [4:0] MODE_LIGHTEN  = 5'd5;
	localparam logic [4:0] MODE_SCREEN   = 5'd6;
	localparam logic [4:0] MODE_DODGE    = 5'd7;
	localparam logic [4:0] MODE_LDODGE   = 5'd8;
	localparam logic [4:0] MODE_OVERLAY  = 5'd9;
	localparam logic [4:0] MODE_HARD     = 5'd10;
	localparam logic [4:0] MODE_SOFT     = 5'd11;
	localparam logic [4:0] MODE_LLIGHT   = 5'd12;
	localparam logic [4:0] MODE_PIN      = 5'd13;
	localparam logic [4:0] MODE_DIFF     = 5'd14;
	localparam logic [4:0] MODE_EXCL     = 5'd15;
	localparam logic [4:0] MODE_SUB      = 5'd16;

	// Register indexes
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_RED     = 3'd1;
	localparam logic [2:0] REG_GREEN   = 3'd2;
	localparam logic [2:0] REG_BLUE    = 3'd3;
	localparam logic [2:0] REG_OPACITY = 3'd4;

	// Settings seen by one lane
	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] color;
		logic [8:0] weight;
	} lane_cfg_t;

	// Square root table: sqrt(p/255) in Q16
	typedef logic [16:0] root_tbl_t [256];

	function automatic root_tbl_t root_tbl_f();
		root_tbl_t tbl;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		for (int p = 0; p < 256; p++) begin
			x = (64'(p) << 32) / 64'd255;
			r = '0;
			for (int k = 31; k >= 0; k--) begin
				b = 64'd1 << (2 * k);
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			tbl[p] = r[16:0];
		end
		return tbl;
	endfunction

	localparam root_tbl_t ROOT_TBL = root_tbl_f();

endpackage

// ===== hdl/cbm_div.sv =====
module cbm_div (
	input  logic        clk,
	input  logic        en,
	input  logic [23:0] num,
	input  logic [7:0]  den,
	output logic [16:0] quo,
	output logic        sat
);
	import cbm_pkg::*;

	logic [23:0] rem_in [DIV_STAGES];
	logic [16:0] quo_in [DIV_STAGES];
	logic [7:0]  den_in [DIV_STAGES];
	logic        sat_in [DIV_STAGES];
	logic [23:0] rem_q  [DIV_STAGES];
	logic [16:0] quo_q  [DIV_STAGES];
	logic [7:0]  den_q  [DIV_STAGES];
	logic        sat_q  [DIV_STAGES];

	// Restoring division, one quotient bit per stage, most significant first
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int BIT = DIV_STAGES - 1 - k;
		logic [24:0] shifted;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in[k] = num;
			assign quo_in[k] = '0;
			assign den_in[k] = den;
			// Quotient would not fit in the stage count
			assign sat_in[k] = {1'b0, num} >= {den, 17'b0};
		end else begin : g_next
			assign rem_in[k] = rem_q[k-1];
			assign quo_in[k] = quo_q[k-1];
			assign den_in[k] = den_q[k-1];
			assign sat_in[k] = sat_q[k-1];
		end

		assign shifted = 25'(den_in[k]) << BIT;
		assign ge = {1'b0, rem_in[k]} >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_in[k] - shifted[23:0] : rem_in[k];
				quo_q[k] <= quo_in[k] | (17'(ge) << BIT);
				den_q[k] <= den_in[k];
				sat_q[k] <= sat_in[k];
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];
	assign sat = sat_q[DIV_STAGES-1];

endmodule

// ===== hdl/cbm_lane.sv =====
module cbm_lane (
	input  logic               clk,
	input  logic               en,
	input  cbm_pkg::lane_cfg_t cfg,
	input  logic [7:0]         pix,
	output logic [7:0]         res
);
	import cbm_pkg::*;

	logic [7:0]  c;
	logic        burn;
	logic        dodge;
	logic [7:0]  nb;
	logic [23:0] div_num;
	logic [7:0]  div_den;
	logic [16:0] quo;
	logic        sat;

	assign c = cfg.color;
	assign burn = cfg.mode == MODE_BURN;
	assign dodge = cfg.mode == MODE_DODGE;
	assign nb = 8'hFF - pix;

	// Divider operands: burn takes (255-p)*65280/c, dodge p*65280/(255-c)
	always_comb begin
		if (burn) begin
			div_num = {nb, 16'b0} - {8'b0, nb, 8'b0};
			div_den = c;
		end else begin
			div_num = {pix, 16'b0} - {8'b0, pix, 8'b0};
			div_den = 8'hFF - c;
		end
	end

	cbm_div u_div (
		.clk (clk),
		.en  (en),
		.num (div_num),
		.den (div_den),
		.quo (quo),
		.sat (sat)
	);

	// Stage 1: products and root lookup
	logic [7:0]  p_s1;
	logic [15:0] pp_s1;
	logic [15:0] pc_s1;
	logic [15:0] qq_s1;
	logic [16:0] root_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pix;
			pp_s1 <= pix * pix;
			pc_s1 <= pix * c;
			qq_s1 <= nb * (8'hFF - c);
			root_s1 <= ROOT_TBL[pix];
		end
	end

	// Stage 2: numerator for the divide-by-255 path
	logic        lo;
	logic [7:0]  k8;
	logic [24:0] soft_lo;
	logic [24:0] soft_hi;
	logic [24:0] excl;
	logic [8:0]  sum_pc;
	logic [24:0] root_prod;
	logic [24:0] x;
	logic [24:0] x_s2;
	logic [16:0] sr_s2;
	logic        lo_s2;
	logic [7:0]  p_s2;

	always_comb begin
		lo = (cfg.mode == MODE_OVERLAY) ? !p_s1[7] : !c[7];
		k8 = 8'hFF - {c[6:0], 1'b0};
		soft_lo = 25'({pc_s1, 9'b0}) - 25'({pc_s1, 1'b0}) + 25'(pp_s1) * 25'(k8);
		soft_hi = 25'({({p_s1, 8'b0} - {8'b0, p_s1} - pc_s1), 1'b0});
		sum_pc = {1'b0, p_s1} + {1'b0, c};
		excl = 25'({sum_pc, 8'b0}) - 25'(sum_pc) - 25'({pc_s1, 1'b0});
		root_prod = root_s1 * {c[6:0], 1'b1};
		case (cfg.mode)
			MODE_MULTIPLY: x = 25'(pc_s1);
			MODE_SCREEN: x = 25'(qq_s1);
			MODE_OVERLAY, MODE_HARD: x = lo ? 25'({pc_s1, 1'b0}) : 25'({qq_s1, 1'b0});
			MODE_EXCL: x = excl;
			MODE_SOFT: x = c[7] ? soft_hi : soft_lo;
			default: x = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x;
			sr_s2 <= root_prod[24:8];
			lo_s2 <= lo;
			p_s2 <= p_s1;
		end
	end

	// Stage 3: quotient by 255 through the reciprocal
	logic [50:0] prod_a;
	logic [15:0] a_s3;
	logic [24:0] x_s3;
	logic [16:0] sr_s3;
	logic        lo_s3;
	logic [7:0]  p_s3;

	assign prod_a = 51'(x_s2) * 51'(RECIP_255);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= prod_a[48:33];
			x_s3 <= x_s2;
			sr_s3 <= sr_s2;
			lo_s3 <= lo_s2;
			p_s3 <= p_s2;
		end
	end

	// Stage 4: x*256/255 as 256*quotient plus remainder
	logic [24:0] remd;
	logic [23:0] y_s4;
	logic [16:0] sr_s4;
	logic        lo_s4;
	logic [7:0]  p_s4;

	assign remd = x_s3 - (25'({a_s3, 8'b0}) - 25'(a_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			y_s4 <= {a_s3, remd[7:0]};
			sr_s4 <= sr_s3;
			lo_s4 <= lo_s3;
			p_s4 <= p_s3;
		end
	end

	// Stage 5: second divide by 255 for soft light with a dark color
	logic [49:0] prod_b;
	logic [15:0] a2_s5;
	logic [23:0] y_s5;
	logic [16:0] sr_s5;
	logic        lo_s5;
	logic [7:0]  p_s5;

	assign prod_b = 50'(y_s4) * 50'(RECIP_255);

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s5 <= prod_b[48:33];
			y_s5 <= y_s4;
			sr_s5 <= sr_s4;
			lo_s5 <= lo_s4;
			p_s5 <= p_s4;
		end
	end

	// Stage 6: blend value for every mode outside the divider
	logic signed [10:0] ps;
	logic signed [10:0] cs;
	logic signed [10:0] e;
	logic [17:0]        u;
	logic               use_e;
	logic [7:0]         e8;
	logic [8:0]         c2;
	logic [15:0]        v;
	logic [15:0]        v_s6;
	logic [7:0]         p_s6;

	always_comb begin
		ps = $signed({3'b0, p_s5});
		cs = $signed({3'b0, c});
		c2 = {c, 1'b0};
		e = '0;
		u = '0;
		use_e = 1'b1;
		case (cfg.mode)
			MODE_NORMAL: e = cs;
			MODE_DARKEN: e = (p_s5 < c) ? ps : cs;
			MODE_LIGHTEN: e = (p_s5 > c) ? ps : cs;
			MODE_LBURN: e = ps + cs - 11'sd255;
			MODE_LDODGE: e = ps + cs;
			MODE_LLIGHT: e = ps + cs + cs - 11'sd255;
			MODE_PIN: begin
				if (!c[7]) begin
					e = ({1'b0, p_s5} < c2) ? ps : $signed({2'b0, c2});
				end else begin
					e = (p_s5 > {c[6:0], 1'b1}) ? ps : $signed({3'b0, c[6:0], 1'b1});
				end
			end
			MODE_DIFF: e = (p_s5 > c) ? ps - cs : cs - ps;
			MODE_SUB: e = ps - cs;
			MODE_BURN, MODE_DODGE: e = '0;
			MODE_MULTIPLY, MODE_EXCL: begin
				use_e = 1'b0;
				u = 18'(y_s5);
			end
			MODE_SCREEN: begin
				use_e = 1'b0;
				u = 18'(FULL_Q8) - 18'(y_s5);
			end
			MODE_OVERLAY, MODE_HARD: begin
				use_e = 1'b0;
				u = lo_s5 ? 18'(y_s5) : 18'(FULL_Q8) - 18'(y_s5);
			end
			MODE_SOFT: begin
				use_e = 1'b0;
				u = c[7] ? 18'(y_s5) + 18'(sr_s5) : 18'(a2_s5);
			end
			default: e = ps;
		endcase
		if (e < 0) begin
			e8 = '0;
		end else if (e > 11'sd255) begin
			e8 = 8'hFF;
		end else begin
			e8 = e[7:0];
		end
		if (use_e) begin
			v = {e8, 8'b0};
		end else if (u > 18'(FULL_Q8)) begin
			v = FULL_Q8;
		end else begin
			v = u[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s6 <= v;
			p_s6 <= p_s5;
		end
	end

	// Delay line that lines the value up with the divider result
	logic [15:0] v_dly_q [DLY_STAGES];
	logic [7:0]  p_dly_q [DLY_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			v_dly_q[0] <= v_s6;
			p_dly_q[0] <= p_s6;
			for (int i = 1; i < DLY_STAGES; i++) begin
				v_dly_q[i] <= v_dly_q[i-1];
				p_dly_q[i] <= p_dly_q[i-1];
			end
		end
	end

	// Stage 18: pick burn, dodge or the other blend value
	logic        big;
	logic [15:0] b;
	logic [15:0] b_s18;
	logic [7:0]  p_s18;

	always_comb begin
		big = sat || (quo > 17'(FULL_Q8));
		if (burn) begin
			b = (c == 8'h00 || big) ? 16'h0000 : FULL_Q8 - quo[15:0];
		end else if (dodge) begin
			b = (c == 8'hFF || big) ? FULL_Q8 : quo[15:0];
		end else begin
			b = v_dly_q[DLY_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s18 <= b;
			p_s18 <= p_dly_q[DLY_STAGES-1];
		end
	end

	// Stage 19: opacity products
	logic [24:0] m1_s19;
	logic [16:0] m2_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s19 <= b_s18 * cfg.weight;
			m2_s19 <= p_s18 * (OPACITY_ONE - cfg.weight);
		end
	end

	// Stage 20: mix, truncate and saturate
	logic [25:0] mix;

	assign mix = 26'(m1_s19) + 26'({m2_s19, 8'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			res <= (mix[25:16] > 10'd255) ? 8'hFF : mix[23:16];
		end
	end

endmodule

// ===== hdl/cbm_merge.sv =====
module cbm_merge (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pv,
	input  logic [7:0]  res_red,
	input  logic [7:0]  res_green,
	input  logic [7:0]  res_blue,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata,
	output logic        en
);
	import cbm_pkg::*;

	logic [23:0] pd;
	logic [23:0] out_q;
	logic [23:0] skid_q;
	logic        out_v_q;
	logic        skid_v_q;
	logic        pop;

	// Pack the lanes into one request
	assign pd = {res_blue, res_green, res_red};
	assign pop = out_v_q && m_tready;
	assign en = !skid_v_q;

	// Output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (pv) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (pv) begin
			if (!out_v_q || pop) begin
				out_q <= pd;
			end else begin
				skid_q <= pd;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

endmodule

// ===== hdl/solid_color_blend_modes.sv =====
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tdata: pixel_red, pixel_green, pixel_blue
// m_*       out        m_tvalid / m_tready        m_tdata: out_red, out_green, out_blue
// APB       in         psel, penable, pready      paddr, pwdata, prdata
//
// One pixel per clock while s_tready is high; each channel lane carries its pixel
// alongside the 17-stage divider that serves color burn and color dodge.
// Reset clears the valid line, output and skid flags, mode and colors; opacity goes to one.
// A stalled output fills the skid entry, and only then is s_tready dropped.
module solid_color_blend_modes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cbm_pkg::*;

	logic [4:0]  mode_q;
	logic [7:0]  color_q [NUM_LANES];
	logic [8:0]  opacity_q;
	logic [8:0]  weight;
	logic        wr;
	logic [2:0]  idx;
	logic        en;
	logic        vld_q [LANE_LAT];
	logic [7:0]  res [NUM_LANES];

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			for (int i = 0; i < NUM_LANES; i++) begin
				color_q[i] <= '0;
			end
			opacity_q <= OPACITY_ONE;
		end else if (wr) begin
			case (idx)
				REG_MODE: mode_q <= pwdata[4:0];
				REG_RED: color_q[0] <= pwdata[7:0];
				REG_GREEN: color_q[1] <= pwdata[7:0];
				REG_BLUE: color_q[2] <= pwdata[7:0];
				REG_OPACITY: opacity_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (idx)
			REG_MODE: prdata = {27'b0, mode_q};
			REG_RED: prdata = {24'b0, color_q[0]};
			REG_GREEN: prdata = {24'b0, color_q[1]};
			REG_BLUE: prdata = {24'b0, color_q[2]};
			REG_OPACITY: prdata = {23'b0, opacity_q};
			default: prdata = '0;
		endcase
	end

	// Opacity above one saturates to a full blend
	assign weight = (opacity_q > OPACITY_ONE) ? OPACITY_ONE : opacity_q;

	// Valid line that follows requests through the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign s_tready = en;

	// One lane per color channel
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		lane_cfg_t cfg;

		assign cfg = '{mode: mode_q, color: color_q[g], weight: weight};

		cbm_lane u_lane (
			.clk (clk),
			.en  (en),
			.cfg (cfg),
			.pix (s_tdata[CHANNEL_BITS*g +: CHANNEL_BITS]),
			.res (res[g])
		);
	end

	cbm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.pv        (vld_q[LANE_LAT-1]),
		.res_red   (res[0]),
		.res_green (res[1]),
		.res_blue  (res[2]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.en        (en)
	);

endmodule
